FILE: src/tlmd_pkg.sv
// shared constants and types for the two-lane mixing digest
package tlmd_pkg;

  localparam logic [63:0] MIX_MUL_ONE  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_TWO  = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] LANE_ADD_ONE = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] LANE_ADD_TWO = 64'h1656_67B1_9E37_79F9;
  localparam logic [63:0] TAIL_MARK    = 64'hFF00_0000_0000_0000;
  localparam logic [63:0] DOMAIN_MARK  = 64'h00FF_0000_0000_0000;
  localparam logic [7:0]  FINISH_TAG   = 8'h5A;

  typedef enum logic [1:0] {
    REQ_DATA    = 2'd0,
    REQ_DOMAIN  = 2'd1,
    REQ_FINISH  = 2'd2,
    REQ_RESTART = 2'd3
  } req_type_t;

  typedef struct packed {
    logic start;
    logic sel_two;
  } mul_cmd_t;

endpackage

FILE: src/tlmd_in_if.sv
// input item channel
interface tlmd_in_if import tlmd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic [7:0]  domain_tag;

  modport source (output valid, req_type, data_word, byte_count, domain_tag, input ready);
  modport sink (input valid, req_type, data_word, byte_count, domain_tag, output ready);
endinterface

FILE: src/tlmd_out_if.sv
// digest result channel
interface tlmd_out_if import tlmd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] digest_high;
  logic [63:0] digest_low;

  modport source (output valid, digest_high, digest_low, input ready);
  modport sink (input valid, digest_high, digest_low, output ready);
endinterface

FILE: src/tlmd_mul.sv
// iterative 64x64 low-half multiplier built on one 32x32 multiplier
module tlmd_mul import tlmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_cmd_t    cmd,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] product
);

  logic        busy;
  logic [1:0]  step;
  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] part;
  logic [63:0] acc;
  logic [31:0] mul_x;
  logic [31:0] mul_y;

  always_comb begin
    case (step)
      2'd1:    mul_x = op_a[63:32];
      default: mul_x = op_a[31:0];
    endcase
    case (step)
      2'd2:    mul_y = op_b[63:32];
      default: mul_y = op_b[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= busy && !cmd.start && (step == 2'd3);
      if (cmd.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_a <= operand;
      op_b <= cmd.sel_two ? MIX_MUL_TWO : MIX_MUL_ONE;
    end
    if (busy) begin
      part <= {32'h0, mul_x} * {32'h0, mul_y};
      case (step)
        2'd1:    acc <= part;
        2'd2:    acc <= acc + {part[31:0], 32'h0};
        2'd3:    acc <= acc + {part[31:0], 32'h0};
        default: acc <= acc;
      endcase
    end
  end

  assign product = acc;

endmodule

FILE: src/two_lane_mix_digest_128_unit.sv
// top level of the two-lane mixing digest
// Keeps two 64-bit hash lanes and a byte total and takes one item at a time.
// Every mix of a word is an absorb round of two scrambles, each scramble two
// 64-bit multiplies by a constant; all multiplies go through one iterative
// multiplier that uses a single 32x32 multiplier. A data item of 8 bytes or a
// domain item mixes one word, a data item of 1 to 7 bytes its masked word and a
// tail word, a finish item the byte total and a finish tag, then a final round
// loads the result register; a restart or an empty data item mixes no word. The
// item channel is not ready while a round runs; a finished digest waits in the
// output register until transferred, and a later finish item holds there until
// the register is free. Seeds are written through the register port at byte
// address 0 (seed_a) and 8 (seed_b) and take effect at the next restart.
module two_lane_mix_digest_128_unit import tlmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tlmd_in_if.sink     item,
  tlmd_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PRE    = 7'b0000010,
    S_MUL_A  = 7'b0000100,
    S_WAIT_A = 7'b0001000,
    S_MUL_B  = 7'b0010000,
    S_WAIT_B = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  localparam logic       REG_SEED_B  = 1'b1;
  localparam logic [1:0] FINAL_ROUND = 2'd2;

  function automatic logic [63:0] byte_mask(input logic [2:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  state_t      state;
  logic [63:0] seed_a;
  logic [63:0] seed_b;
  logic [63:0] lane_one;
  logic [63:0] lane_two;
  logic [63:0] byte_total;
  logic [63:0] c1;
  logic [63:0] c2;
  logic [63:0] word0;
  logic [63:0] word1;
  logic [63:0] v;
  logic [63:0] x;
  logic [1:0]  rnd;
  logic [1:0]  rnd_last;
  logic        fin;
  logic        half;
  logic        out_valid;
  logic [63:0] digest_high;
  logic [63:0] digest_low;

  mul_cmd_t    mul_cmd;
  logic [63:0] mul_operand;
  logic        mul_done;
  logic [63:0] mul_product;

  logic [63:0] w;
  logic        final_rnd;
  logic [63:0] pre_x;
  logic [63:0] pre_y;
  logic [63:0] scr;
  logic [63:0] mix_a;
  logic [63:0] mix_b;
  logic        in_xfer;
  logic        cfg_write;
  logic [3:0]  cnt_sat;

  tlmd_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mul_cmd),
    .operand (mul_operand),
    .done    (mul_done),
    .product (mul_product)
  );

  assign w         = rnd[0] ? word1 : word0;
  assign final_rnd = fin && (rnd == FINAL_ROUND);
  assign pre_x     = final_rnd ? (c1 ^ (c2 + LANE_ADD_ONE)) : (c1 ^ (w + LANE_ADD_ONE));
  assign pre_y     = final_rnd ? (c2 ^ (c1 + LANE_ADD_TWO)) : (c2 + w + LANE_ADD_TWO);
  assign scr       = mul_product ^ (mul_product >> 31);
  assign mix_a     = x ^ (scr >> 29);
  assign mix_b     = scr ^ (x << 17);

  assign mul_cmd.start   = (state == S_MUL_A) || (state == S_MUL_B);
  assign mul_cmd.sel_two = (state == S_MUL_B);
  assign mul_operand     = (state == S_MUL_B) ? (v ^ (v >> 27)) : (v ^ (v >> 30));

  assign item.ready = (state == S_IDLE);
  assign in_xfer    = item.valid && item.ready;
  assign cnt_sat    = item.byte_count[3] ? 4'd8 : item.byte_count;

  assign result.valid       = out_valid;
  assign result.digest_high = digest_high;
  assign result.digest_low  = digest_low;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[3] == REG_SEED_B) ? seed_b : seed_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seed_a     <= '0;
      seed_b     <= '0;
      lane_one   <= '0;
      lane_two   <= '0;
      byte_total <= '0;
      out_valid  <= 1'b0;
      rnd        <= 2'd0;
      rnd_last   <= 2'd0;
      fin        <= 1'b0;
      half       <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[3] == REG_SEED_B) begin
          seed_b <= pwdata;
        end else begin
          seed_a <= pwdata;
        end
      end

      if ((state == S_EMIT) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          c1   <= lane_one;
          c2   <= lane_two;
          rnd  <= 2'd0;
          half <= 1'b0;
          if (in_xfer) begin
            case (item.req_type)
              REQ_DATA: begin
                if (item.byte_count != 4'd0) begin
                  byte_total <= byte_total + {60'h0, cnt_sat};
                  word0      <= item.byte_count[3] ? item.data_word
                              : (item.data_word & byte_mask(item.byte_count[2:0]));
                  word1      <= TAIL_MARK | {60'h0, item.byte_count};
                  rnd_last   <= item.byte_count[3] ? 2'd0 : 2'd1;
                  fin        <= 1'b0;
                  state      <= S_PRE;
                end
              end
              REQ_DOMAIN: begin
                word0    <= DOMAIN_MARK | {56'h0, item.domain_tag};
                rnd_last <= 2'd0;
                fin      <= 1'b0;
                state    <= S_PRE;
              end
              REQ_FINISH: begin
                word0    <= byte_total;
                word1    <= DOMAIN_MARK | {56'h0, FINISH_TAG};
                rnd_last <= FINAL_ROUND;
                fin      <= 1'b1;
                state    <= S_PRE;
              end
              default: begin
                lane_one   <= seed_a;
                lane_two   <= seed_b;
                byte_total <= '0;
              end
            endcase
          end
        end
        S_PRE: begin
          v     <= half ? pre_y : pre_x;
          state <= S_MUL_A;
        end
        S_MUL_A: begin
          state <= S_WAIT_A;
        end
        S_WAIT_A: begin
          if (mul_done) begin
            v     <= mul_product;
            state <= S_MUL_B;
          end
        end
        S_MUL_B: begin
          state <= S_WAIT_B;
        end
        S_WAIT_B: begin
          if (mul_done) begin
            if (!half) begin
              x     <= scr;
              half  <= 1'b1;
              state <= S_PRE;
            end else begin
              half <= 1'b0;
              if (final_rnd) begin
                v     <= scr;
                state <= S_EMIT;
              end else begin
                c1 <= mix_a;
                c2 <= mix_b;
                if (rnd == rnd_last) begin
                  lane_one <= mix_a;
                  lane_two <= mix_b;
                  state    <= S_IDLE;
                end else begin
                  rnd   <= rnd + 2'd1;
                  state <= S_PRE;
                end
              end
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            digest_high <= x;
            digest_low  <= ((x == 64'h0) && (v == 64'h0)) ? 64'h1 : v;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/tlmd_chk.sv
// port-level checks for the digest unit, bound to the top level
module tlmd_chk import tlmd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic [3:0]  in_byte_count,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_high,
  input logic [63:0] digest_low
);

  logic in_xfer;
  logic long_item;

  assign in_xfer   = in_valid && in_ready;
  assign long_item = (in_req_type == REQ_DOMAIN) || (in_req_type == REQ_FINISH)
                  || ((in_req_type == REQ_DATA) && (in_byte_count != 4'd0));

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_high) && $stable(digest_low)))
    else $error("result changed while stalled");

  // digest is never all zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digest_high != 64'h0) || (digest_low != 64'h0)))
    else $error("all-zero digest");

  // a new result only appears while the item side is busy
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in progress");

  // items that mix words keep the item side busy
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && long_item) |=> !in_ready)
    else $error("ready right after a mixing item");

endmodule

bind two_lane_mix_digest_128_unit tlmd_chk u_tlmd_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item.valid),
  .in_ready      (item.ready),
  .in_req_type   (item.req_type),
  .in_byte_count (item.byte_count),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .digest_high   (result.digest_high),
  .digest_low    (result.digest_low)
);

FILE: test/two_lane_mix_digest_128_unit_tb.sv
// testbench for the two-lane mixing digest: directed and random items checked against a predictor
`timescale 1ns / 1ps

module two_lane_mix_digest_128_unit_tb;
  import tlmd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    SEED_A_ADDR = 4'h0,
    SEED_B_ADDR = 4'h8
  } seed_addr_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  tlmd_in_if  item_if ();
  tlmd_out_if result_if ();

  two_lane_mix_digest_128_unit dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [63:0] seed_x;
  logic [63:0] seed_y;
  logic [63:0] lane_x;
  logic [63:0] lane_y;
  logic [63:0] total_bytes;
  digest_t     digest_queue[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        holding = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] mix64(logic [63:0] v);
    v = (v ^ (v >> 30)) * MIX_MUL_ONE;
    v = (v ^ (v >> 27)) * MIX_MUL_TWO;
    return v ^ (v >> 31);
  endfunction

  function automatic void fold_word(inout logic [63:0] a, inout logic [63:0] b,
                                    input logic [63:0] w);
    logic [63:0] x;
    logic [63:0] y;
    x = mix64(a ^ (w + LANE_ADD_ONE));
    y = mix64(b + w + LANE_ADD_TWO);
    a = x ^ (y >> 29);
    b = y ^ (x << 17);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void apply_item(req_type_t req, logic [63:0] word, logic [3:0] count,
                                     logic [7:0] tag);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] mask;
    digest_t     d;
    case (req)
      REQ_DATA: begin
        if (count >= 4'd8) begin
          fold_word(lane_x, lane_y, word);
          total_bytes += 64'd8;
        end else if (count != 4'd0) begin
          mask = (64'd1 << (8 * count)) - 64'd1;
          fold_word(lane_x, lane_y, word & mask);
          fold_word(lane_x, lane_y, TAIL_MARK | {60'd0, count});
          total_bytes += {60'd0, count};
        end
      end
      REQ_DOMAIN: begin
        fold_word(lane_x, lane_y, DOMAIN_MARK | {56'd0, tag});
      end
      REQ_RESTART: begin
        lane_x = seed_x;
        lane_y = seed_y;
        total_bytes = 64'd0;
      end
      default: begin
        a = lane_x;
        b = lane_y;
        fold_word(a, b, total_bytes);
        fold_word(a, b, DOMAIN_MARK | {56'd0, FINISH_TAG});
        d.high = mix64(a ^ (b + LANE_ADD_ONE));
        d.low  = mix64(b ^ (a + LANE_ADD_TWO));
        if (d.high == 64'd0 && d.low == 64'd0) begin
          d.low = 64'd1;
        end
        digest_queue.push_back(d);
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch on %s: got %h, want %h", field, got, want);
    error_count++;
  endtask

  task automatic check_digest();
    digest_t want;
    if (digest_queue.size() == 0) begin
      report_mismatch("unexpected digest", result_if.digest_high, result_if.digest_low);
    end else begin
      want = digest_queue.pop_front();
      if (result_if.digest_high !== want.high) begin
        report_mismatch("digest_high", result_if.digest_high, want.high);
      end
      if (result_if.digest_low !== want.low) begin
        report_mismatch("digest_low", result_if.digest_low, want.low);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      check_digest();
    end
    result_if.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic hold_off(int cycles);
    holding <= 1'b1;
    repeat (cycles) @(posedge clk);
    holding <= 1'b0;
  endtask

  task automatic send_item(req_type_t req, logic [63:0] word, logic [3:0] count,
                           logic [7:0] tag);
    if ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_if.valid      <= 1'b1;
    item_if.req_type   <= req;
    item_if.data_word  <= word;
    item_if.byte_count <= count;
    item_if.domain_tag <= tag;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    apply_item(req, word, count, tag);
    if (!(req == REQ_DATA && count == 4'd0)) begin
      items_sent++;
    end
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(seed_addr_t addr, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SEED_A_ADDR) begin
      seed_x = value;
    end else begin
      seed_y = value;
    end
    @(posedge clk);
  endtask

  task automatic apply_seeds(logic [63:0] a, logic [63:0] b);
    settle();
    write_seed(SEED_A_ADDR, a);
    write_seed(SEED_B_ADDR, b);
    send_item(REQ_RESTART, rand64(), 4'($urandom_range(0, 15)), 8'($urandom));
  endtask

  task automatic send_message();
    int full_words;
    if ($urandom_range(7) == 0) begin
      send_item(REQ_RESTART, rand64(), 4'($urandom_range(0, 15)), 8'($urandom));
    end
    if ($urandom_range(3) == 0) begin
      send_item(REQ_DOMAIN, rand64(), 4'($urandom_range(0, 15)), 8'($urandom));
    end
    full_words = $urandom_range(0, 4);
    repeat (full_words) begin
      send_item(REQ_DATA, rand64(),
                ($urandom_range(4) == 0) ? 4'($urandom_range(8, 15)) : 4'd8, 8'($urandom));
    end
    send_item(REQ_DATA, rand64(), 4'($urandom_range(0, 7)), 8'($urandom));
    if ($urandom_range(3) != 0) begin
      send_item(REQ_FINISH, rand64(), 4'($urandom_range(0, 15)), 8'($urandom));
    end
  endtask

  task automatic test_reset_defaults();
    send_item(REQ_FINISH, 64'd0, 4'd0, 8'd0);
    send_item(REQ_DATA, ALL_ONES, 4'd0, 8'hFF);
    send_item(REQ_FINISH, ALL_ONES, 4'hF, 8'hFF);
  endtask

  task automatic test_data_lengths();
    apply_seeds(ALL_ONES, 64'd0);
    send_item(REQ_DATA, ALL_ONES, 4'd8, 8'd0);
    for (int n = 1; n < 8; n++) begin
      send_item(REQ_DATA, ALL_ONES, 4'(n), 8'hFF);
    end
    send_item(REQ_DATA, rand64(), 4'd9, 8'd0);
    send_item(REQ_DATA, rand64(), 4'd15, 8'd0);
    send_item(REQ_DATA, 64'd0, 4'd8, 8'd0);
    send_item(REQ_FINISH, 64'd0, 4'd0, 8'd0);
  endtask

  task automatic test_domain_and_restart();
    apply_seeds(64'd0, ALL_ONES);
    send_item(REQ_DOMAIN, ALL_ONES, 4'hF, 8'd0);
    send_item(REQ_DOMAIN, 64'd0, 4'd0, 8'hFF);
    send_item(REQ_FINISH, rand64(), 4'd8, 8'h5A);
    send_item(REQ_RESTART, ALL_ONES, 4'hF, 8'hFF);
    send_item(REQ_FINISH, 64'd0, 4'd0, 8'd0);
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      hold_off(600);
    join_none
    repeat (5) begin
      send_item(REQ_DATA, rand64(), 4'd8, 8'($urandom));
      send_item(REQ_FINISH, rand64(), 4'($urandom_range(0, 15)), 8'($urandom));
    end
    settle();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int item_goal);
    int first;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = items_sent;
    while (items_sent - first < item_goal) begin
      if ($urandom_range(99) < 15) begin
        send_item(req_type_t'($urandom_range(0, 3)), rand64(), 4'($urandom_range(0, 15)),
                  8'($urandom));
      end else begin
        send_message();
      end
    end
    settle();
  endtask

  initial begin
    rst                = 1'b1;
    item_if.valid      = 1'b0;
    item_if.req_type   = REQ_DATA;
    item_if.data_word  = 64'd0;
    item_if.byte_count = 4'd0;
    item_if.domain_tag = 8'd0;
    result_if.ready    = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = SEED_A_ADDR;
    pwdata             = 64'd0;
    seed_x             = 64'd0;
    seed_y             = 64'd0;
    lane_x             = 64'd0;
    lane_y             = 64'd0;
    total_bytes        = 64'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_data_lengths();
    test_domain_and_restart();
    test_output_stall();
    apply_seeds(rand64(), rand64());
    test_random_traffic(23, 64, 200);
    apply_seeds(ALL_ONES, ALL_ONES);
    test_random_traffic(64, 23, 200);
    apply_seeds(64'd0, rand64());
    test_random_traffic(0, 0, 200);
    settle();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
